/* rtl/glyph_cache_lru_tags_defines.svh */
// Assertion macros for the glyph cache checker file.
`ifndef GLYPH_CACHE_LRU_TAGS_DEFINES_SVH
`define GLYPH_CACHE_LRU_TAGS_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define GCLT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph cache tag check failed");

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define GCLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph cache tag check failed");

`endif

/* rtl/gclt_pkg.sv */
`default_nettype none

package gclt_pkg;

    localparam int ENTRIES  = 128;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int NUM_W    = $clog2(ENTRIES + 1);
    localparam int TAG_BITS = 16;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 8;
    localparam int GLYPH_W  = 16;
    localparam int SLOT_W   = 7;
    localparam int USED_W   = 8;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 8'd96;

    localparam logic [1:0] STATUS_HIT   = 2'd0;
    localparam logic [1:0] STATUS_FILL  = 2'd1;
    localparam logic [1:0] STATUS_EVICT = 2'd2;
    localparam logic [1:0] STATUS_FAIL  = 2'd3;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_tag;
        logic               fill_ok;
    } gclt_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [GLYPH_W-1:0] victim_tag;
        logic [CNT_W-1:0]   hits_total;
        logic [CNT_W-1:0]   misses_total;
        logic [CNT_W-1:0]   evictions_total;
        logic [USED_W-1:0]  entries_used;
    } gclt_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } gclt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_addr;
        logic out_free;
    } gclt_sts_t;

endpackage

`default_nettype wire

/* rtl/gclt_ram.sv */
`default_nettype none

module gclt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/gclt_ctrl.sv */
`default_nettype none

module gclt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    output gclt_pkg::gclt_cmd_t       cmd,
    input  wire gclt_pkg::gclt_sts_t  sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.last_addr)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gclt_datapath.sv */
`default_nettype none

module gclt_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gclt_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire gclt_pkg::gclt_req_t           req,
    input  wire gclt_pkg::gclt_cmd_t           cmd,
    output gclt_pkg::gclt_sts_t                sts,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output gclt_pkg::gclt_rsp_t                rsp
);

    // Configuration and the latched request.
    logic [gclt_pkg::CFG_W-1:0]    cfg_reg;
    logic [gclt_pkg::TAG_BITS-1:0] key_reg;
    logic                          fill_ok_reg;
    logic [gclt_pkg::NUM_W-1:0]    n_reg;
    logic [gclt_pkg::NUM_W-1:0]    n_eff;

    // Scan address and compare stage.
    logic [gclt_pkg::IDX_W-1:0]    scan_idx_reg;
    logic                          cmp_vld_reg;
    logic [gclt_pkg::IDX_W-1:0]    cmp_idx_reg;

    // Scan results.
    logic                          hit_found_reg;
    logic [gclt_pkg::IDX_W-1:0]    hit_idx_reg;
    logic                          free_found_reg;
    logic [gclt_pkg::IDX_W-1:0]    free_idx_reg;
    logic                          min_have_reg;
    logic [gclt_pkg::IDX_W-1:0]    min_idx_reg;
    logic [gclt_pkg::STAMP_W-1:0]  min_stamp_reg;
    logic [gclt_pkg::TAG_BITS-1:0] min_tag_reg;

    // Architectural state.
    logic [gclt_pkg::ENTRIES-1:0]  valid_reg;
    logic [gclt_pkg::ENTRIES-1:0]  valid_next;
    logic [gclt_pkg::STAMP_W-1:0]  use_clock_reg;
    logic [gclt_pkg::STAMP_W-1:0]  use_clock_next;
    logic [gclt_pkg::CNT_W-1:0]    hit_cnt_reg;
    logic [gclt_pkg::CNT_W-1:0]    hit_cnt_next;
    logic [gclt_pkg::CNT_W-1:0]    miss_cnt_reg;
    logic [gclt_pkg::CNT_W-1:0]    miss_cnt_next;
    logic [gclt_pkg::CNT_W-1:0]    evict_cnt_reg;
    logic [gclt_pkg::CNT_W-1:0]    evict_cnt_next;
    logic [gclt_pkg::NUM_W-1:0]    fill_cnt_reg;
    logic [gclt_pkg::NUM_W-1:0]    fill_cnt_next;

    // Output register.
    gclt_pkg::gclt_rsp_t           rsp_reg;
    gclt_pkg::gclt_rsp_t           rsp_next;
    logic                          rsp_valid_reg;

    // Memory ports.
    logic [gclt_pkg::IDX_W-1:0]    ram_addr;
    logic [gclt_pkg::TAG_BITS-1:0] tag_rd;
    logic [gclt_pkg::STAMP_W-1:0]  stamp_rd;
    logic                          tag_we;
    logic                          stamp_we;

    // Commit decision.
    logic [gclt_pkg::IDX_W-1:0]    slot_sel;
    logic                          ent_valid;
    logic                          ent_hit;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = gclt_pkg::NUM_W'(1);
        end
        else if (int'(cfg_reg) > gclt_pkg::ENTRIES)
        begin
            n_eff = gclt_pkg::NUM_W'(gclt_pkg::ENTRIES);
        end
        else
        begin
            n_eff = gclt_pkg::NUM_W'(cfg_reg);
        end
    end

    assign sts.last_addr = (gclt_pkg::NUM_W'(scan_idx_reg) == (n_reg - 1'b1));
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    assign ent_valid = valid_reg[cmp_idx_reg];
    assign ent_hit   = ent_valid && (tag_rd == key_reg);

    // Work out the outcome of the request from the finished scan.
    always_comb
    begin
        slot_sel       = '0;
        tag_we         = 1'b0;
        stamp_we       = 1'b0;
        valid_next     = valid_reg;
        use_clock_next = use_clock_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        rsp_next       = '0;
        rsp_next.status = gclt_pkg::STATUS_FAIL;

        if (hit_found_reg)
        begin
            slot_sel        = hit_idx_reg;
            stamp_we        = 1'b1;
            use_clock_next  = use_clock_reg + 1'b1;
            hit_cnt_next    = hit_cnt_reg + 1'b1;
            rsp_next.status = gclt_pkg::STATUS_HIT;
        end
        else
        begin
            miss_cnt_next = miss_cnt_reg + 1'b1;
            if (fill_ok_reg)
            begin
                tag_we         = 1'b1;
                stamp_we       = 1'b1;
                use_clock_next = use_clock_reg + 1'b1;
                if (free_found_reg)
                begin
                    slot_sel        = free_idx_reg;
                    rsp_next.status = gclt_pkg::STATUS_FILL;
                    if (fill_cnt_reg < n_reg)
                    begin
                        fill_cnt_next = fill_cnt_reg + 1'b1;
                    end
                end
                else
                begin
                    slot_sel            = min_idx_reg;
                    rsp_next.status     = gclt_pkg::STATUS_EVICT;
                    rsp_next.victim_tag = gclt_pkg::GLYPH_W'(min_tag_reg);
                    evict_cnt_next      = evict_cnt_reg + 1'b1;
                end
                valid_next[slot_sel] = 1'b1;
            end
        end

        rsp_next.slot            = gclt_pkg::SLOT_W'(slot_sel);
        rsp_next.hits_total      = hit_cnt_next;
        rsp_next.misses_total    = miss_cnt_next;
        rsp_next.evictions_total = evict_cnt_next;
        rsp_next.entries_used    = gclt_pkg::USED_W'(fill_cnt_next);
    end

    assign ram_addr = cmd.commit ? slot_sel : scan_idx_reg;

    gclt_ram #(
        .WIDTH (gclt_pkg::TAG_BITS),
        .DEPTH (gclt_pkg::ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit && tag_we),
        .addr  (ram_addr),
        .wdata (key_reg),
        .rdata (tag_rd)
    );

    gclt_ram #(
        .WIDTH (gclt_pkg::STAMP_W),
        .DEPTH (gclt_pkg::ENTRIES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (cmd.commit && stamp_we),
        .addr  (ram_addr),
        .wdata (use_clock_next),
        .rdata (stamp_rd)
    );

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= gclt_pkg::ENTRIES_RESET;
            cmp_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            use_clock_reg  <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            fill_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            min_have_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            cmp_vld_reg <= cmd.issue;

            if (cmd.load)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                min_have_reg   <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (ent_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!ent_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                else
                begin
                    min_have_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                valid_reg     <= valid_next;
                use_clock_reg <= use_clock_next;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
                fill_cnt_reg  <= fill_cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= gclt_pkg::TAG_BITS'(req.glyph_tag);
            fill_ok_reg  <= req.fill_ok;
            n_reg        <= n_eff;
            scan_idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end

        cmp_idx_reg <= scan_idx_reg;

        if (cmp_vld_reg && !cmd.load)
        begin
            if (ent_hit && !hit_found_reg)
            begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!ent_valid && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
            // Strict less-than keeps the lowest entry number on a tie.
            if (ent_valid && (!min_have_reg || (stamp_rd < min_stamp_reg)))
            begin
                min_idx_reg   <= cmp_idx_reg;
                min_stamp_reg <= stamp_rd;
                min_tag_reg   <= tag_rd;
            end
        end

        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

/* rtl/glyph_cache_lru_tags.sv */
// Channel    Direction  Handshake              Payload
// req        in         req_valid/req_ready    gclt_req_t: glyph_tag, fill_ok
// rsp        out        rsp_valid/rsp_ready    gclt_rsp_t: status, slot, victim_tag,
//                                              counters, entries_used
// cfg        in         cfg_we (no wait)       cfg_wdata: entries_in_use
//
// A request is accepted in idle and then scanned over n entries, where n is the effective
// entry count (entries_in_use clamped to 1..ENTRIES). The scan walks the single-port tag
// and stamp memories one entry per cycle; a drain state then takes the last read, a commit
// state the update, and idle accepts the next request. The result appears in the cycle after
// the update and is held until taken; a new request is accepted while it waits, and its
// update waits only while the old result is unread. Reset clears valid bits and counters.
`default_nettype none

module glyph_cache_lru_tags (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gclt_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire gclt_pkg::gclt_req_t         req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output gclt_pkg::gclt_rsp_t              rsp
);

    // Commands and status between the sequencer and the datapath.
    gclt_pkg::gclt_cmd_t cmd;
    gclt_pkg::gclt_sts_t sts;

    // The sequencer steps through accept, scan, drain and commit.
    gclt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the memories, the scan compare stage, the valid bits,
    // the counters and the output register.
    gclt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* rtl/gclt_checker.sv */
`default_nettype none

`include "glyph_cache_lru_tags_defines.svh"

module gclt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire gclt_pkg::gclt_rsp_t rsp
);

    // A waiting result must not change under a stall.
    `GCLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // After a request is taken the block is busy scanning.
    `GCLT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // A failed fill reports neither a slot nor a victim.
    `GCLT_ASSERT_NOW(a_fail_clean, rsp_valid && (rsp.status == gclt_pkg::STATUS_FAIL),
        (rsp.slot == '0) && (rsp.victim_tag == '0))

    // Only an eviction carries a victim tag.
    `GCLT_ASSERT_NOW(a_victim_only_evict, rsp_valid && (rsp.status != gclt_pkg::STATUS_EVICT),
        rsp.victim_tag == '0)

endmodule

bind glyph_cache_lru_tags gclt_checker u_gclt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

/* dv/glyph_cache_lru_tags_tb.sv */
`timescale 1ns / 100ps

// Testbench for the glyph cache tag and replacement controller.
module glyph_cache_lru_tags_tb;
    import gclt_pkg::*;

    // Run shape. A phase is a run of beats under one entries_in_use setting.
    localparam int NUM_PHASES  = 13;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_PHASE  = 4;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 150;
    localparam int LIMIT       = 2_000_000;
    localparam int MAX_LINES   = 40;

    // The first phases sweep the interesting settings: zero (acts as one), the
    // built depth, one, the largest register value, two, the reset value and
    // just above the depth. Later phases pick settings at random.
    localparam logic [CFG_W-1:0] FIXED_SPANS [7] =
        '{8'd0, 8'd128, 8'd1, 8'd255, 8'd2, 8'd96, 8'd129};

    // One row of the directed table. When set_cfg is high the register is
    // rewritten before the beat goes out. When typed is high the expected
    // result is the one written in the row; otherwise the predictor decides.
    typedef struct packed {
        logic             set_cfg;
        logic [CFG_W-1:0] cfg;
        gclt_req_t        req;
        logic             typed;
        gclt_rsp_t        rsp;
    } plan_row_t;

    localparam int PLAN_ROWS = 16;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // Reset value of 96 entries: fills, a hit, a failed fill, and a hit
        // that ignores fill_ok.
        '{1'b0, 8'd0, '{16'h0000, 1'b1}, 1'b1,
          '{STATUS_FILL, 7'd0, 16'h0000, 32'd0, 32'd1, 32'd0, 8'd1}},
        '{1'b0, 8'd0, '{16'hFFFF, 1'b1}, 1'b1,
          '{STATUS_FILL, 7'd1, 16'h0000, 32'd0, 32'd2, 32'd0, 8'd2}},
        '{1'b0, 8'd0, '{16'h0000, 1'b1}, 1'b1,
          '{STATUS_HIT, 7'd0, 16'h0000, 32'd1, 32'd2, 32'd0, 8'd2}},
        '{1'b0, 8'd0, '{16'h1234, 1'b0}, 1'b1,
          '{STATUS_FAIL, 7'd0, 16'h0000, 32'd1, 32'd3, 32'd0, 8'd2}},
        '{1'b0, 8'd0, '{16'hFFFF, 1'b0}, 1'b1,
          '{STATUS_HIT, 7'd1, 16'h0000, 32'd2, 32'd3, 32'd0, 8'd2}},
        // Zero entries acts as one: only entry 0 is searched, so the second
        // tag misses and evicts entry 0 without touching the used count.
        '{1'b1, 8'd0, '{16'h0000, 1'b1}, 1'b1,
          '{STATUS_HIT, 7'd0, 16'h0000, 32'd3, 32'd3, 32'd0, 8'd2}},
        '{1'b0, 8'd0, '{16'hFFFF, 1'b1}, 1'b1,
          '{STATUS_EVICT, 7'd0, 16'h0000, 32'd3, 32'd4, 32'd1, 8'd2}},
        '{1'b0, 8'd0, '{16'hAAAA, 1'b0}, 1'b1,
          '{STATUS_FAIL, 7'd0, 16'h0000, 32'd3, 32'd5, 32'd1, 8'd2}},
        // Two entries: duplicate tags in entries 0 and 1, then an LRU eviction.
        '{1'b1, 8'd2, '{16'hFFFF, 1'b1}, 1'b0, '0},
        '{1'b0, 8'd0, '{16'h5555, 1'b1}, 1'b0, '0},
        // Above the built depth acts as the full depth.
        '{1'b1, 8'd255, '{16'h8000, 1'b1}, 1'b0, '0},
        '{1'b0, 8'd0, '{16'h0001, 1'b1}, 1'b0, '0},
        '{1'b1, 8'd128, '{16'h5555, 1'b1}, 1'b0, '0},
        '{1'b0, 8'd0, '{16'h7FFF, 1'b0}, 1'b0, '0},
        // Shrink back to one entry while the outer entries keep their tags.
        '{1'b1, 8'd1, '{16'h8000, 1'b1}, 1'b0, '0},
        '{1'b0, 8'd0, '{16'hFFFF, 1'b1}, 1'b0, '0}
    };

    // Block ports. Every input starts at a known value.
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    gclt_req_t        req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    gclt_rsp_t        rsp;

    // Travels with the request beat: a typed expectation from the table.
    logic      exp_typed = 1'b0;
    gclt_rsp_t typed_rsp = '0;

    // Flow control of the receiving side.
    logic calm    = 1'b0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;
    int   stall_left = 0;

    int errors = 0;

    // Shadow copy of the cache: tags, stamps, counters and the register.
    logic             shadow_valid [ENTRIES];
    logic [15:0]      shadow_tag   [ENTRIES];
    logic [31:0]      shadow_stamp [ENTRIES];
    logic [31:0]      use_clock  = '0;
    logic [31:0]      hit_cnt    = '0;
    logic [31:0]      miss_cnt   = '0;
    logic [31:0]      evict_cnt  = '0;
    int               fill_cnt   = 0;
    logic [CFG_W-1:0] span_cfg   = ENTRIES_RESET;

    // Results the block still owes, oldest first.
    gclt_rsp_t awaited_rsp [$];

    glyph_cache_lru_tags dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_stamp[i] = '0;
        end
    end

    // The register value as the block uses it: zero acts as one, and anything
    // above the built depth acts as the full depth.
    function automatic int active_span(input logic [CFG_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > ENTRIES)
            return ENTRIES;
        return int'(v);
    endfunction

    // Predicts the result of one lookup and updates the shadow cache.
    function automatic gclt_rsp_t cache_lookup(input gclt_req_t r);
        gclt_rsp_t   o;
        int          n;
        int          slot;
        int          hit_at;
        int          free_at;
        logic [15:0] victim;
        n       = active_span(span_cfg);
        hit_at  = -1;
        free_at = -1;
        slot    = 0;
        victim  = '0;
        o       = '0;
        o.status = STATUS_FAIL;
        for (int i = 0; i < n; i++)
        begin
            if (shadow_valid[i] && shadow_tag[i] == r.glyph_tag)
            begin
                hit_at = i;
                break;
            end
        end
        if (hit_at >= 0)
        begin
            // A hit refreshes the stamp; fill_ok plays no part.
            use_clock            = use_clock + 1;
            shadow_stamp[hit_at] = use_clock;
            hit_cnt              = hit_cnt + 1;
            o.status             = STATUS_HIT;
            slot                 = hit_at;
        end
        else
        begin
            miss_cnt = miss_cnt + 1;
            if (r.fill_ok)
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (!shadow_valid[i])
                    begin
                        free_at = i;
                        break;
                    end
                end
                if (free_at >= 0)
                begin
                    o.status = STATUS_FILL;
                    slot     = free_at;
                    if (fill_cnt < n)
                        fill_cnt++;
                end
                else
                begin
                    // Oldest stamp goes; a tie keeps the lowest entry. The
                    // comparison stays a plain unsigned one across a wrap.
                    for (int i = 1; i < n; i++)
                    begin
                        if (shadow_stamp[i] < shadow_stamp[slot])
                            slot = i;
                    end
                    o.status  = STATUS_EVICT;
                    victim    = shadow_tag[slot];
                    evict_cnt = evict_cnt + 1;
                end
                shadow_valid[slot] = 1'b1;
                shadow_tag[slot]   = r.glyph_tag;
                use_clock          = use_clock + 1;
                shadow_stamp[slot] = use_clock;
            end
        end
        o.slot            = SLOT_W'(slot);
        o.victim_tag      = victim;
        o.hits_total      = hit_cnt;
        o.misses_total    = miss_cnt;
        o.evictions_total = evict_cnt;
        o.entries_used    = USED_W'(fill_cnt);
        return o;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic note_error(input string msg);
        if (errors < MAX_LINES)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    // Offers one request beat, after an optional idle burst, and returns at
    // the edge where it is accepted. Valid stays high on return so that a
    // following beat can go out back to back.
    task automatic offer(input gclt_req_t r, input logic typed, input gclt_rsp_t want);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        exp_typed <= typed;
        typed_rsp <= want;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // The register is only written while the block is idle.
    task automatic set_entries(input logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        span_cfg   = v;
    endtask

    // Request side monitor: every accepted beat gets its expectation here.
    always @(posedge clk)
    begin : accept_mon
        gclt_rsp_t forecast;
        if (rst_n && req_valid && req_ready)
        begin
            forecast = cache_lookup(req);
            if (exp_typed)
                awaited_rsp.push_back(typed_rsp);
            else
                awaited_rsp.push_back(forecast);
        end
    end

    // Result side monitor: each accepted result is held against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : result_mon
        gclt_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
                note_error("result beat with nothing awaited");
            else
            begin
                want = awaited_rsp.pop_front();
                check_field("status", 32'(rsp.status), 32'(want.status));
                check_field("slot", 32'(rsp.slot), 32'(want.slot));
                check_field("victim_tag", 32'(rsp.victim_tag), 32'(want.victim_tag));
                check_field("hits_total", rsp.hits_total, want.hits_total);
                check_field("misses_total", rsp.misses_total, want.misses_total);
                check_field("evictions_total", rsp.evictions_total,
                            want.evictions_total);
                check_field("entries_used", 32'(rsp.entries_used),
                            32'(want.entries_used));
            end
        end
    end

    // Receiver: random stall bursts, the long hold-off, and a calm tail.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if (hold_on)
            rsp_ready <= 1'b0;
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Long hold-off: the receiver stops for a long stretch while the sender
    // keeps offering, so the block fills its result slot and then refuses
    // new requests until the hold ends.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Watchdog, sized for the slowest legal run several times over.
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("glyph_cache_lru_tags regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int          n;
        int          pool;
        int          pick;
        logic [15:0] pool_base;
        logic [CFG_W-1:0] v;
        gclt_req_t   r;
        pool_base = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. The first rows run on the reset value of the
        // register, so it is not written before them.
        for (int k = 0; k < PLAN_ROWS; k++)
        begin
            if (PLAN[k].set_cfg)
                set_entries(PLAN[k].cfg);
            offer(PLAN[k].req, PLAN[k].typed, PLAN[k].rsp);
        end

        // Random phases. Tags come mostly from a working set about one and a
        // half times the active span, so hits, free fills and evictions all
        // occur. The set keeps its base across some phases so that entries
        // left outside a shrunken range can hit again once it grows.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 7)
                v = FIXED_SPANS[ph];
            else if ($urandom_range(0, 4) == 0)
                v = CFG_W'($urandom_range(17, 255));
            else
                v = CFG_W'($urandom_range(3, 16));
            set_entries(v);
            n    = active_span(v);
            pool = n + n / 2 + 1;
            if (ph == 0 || $urandom_range(0, 1) == 1)
                pool_base = 16'($urandom);
            if (ph == HOLD_PHASE)
                hold_go = 1'b1;
            if (ph == NUM_PHASES - 1)
                calm <= 1'b1;
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    r.glyph_tag = pool_base ^ 16'($urandom_range(0, pool - 1));
                else if (pick < 92)
                    r.glyph_tag = 16'($urandom);
                else if (pick < 96)
                    r.glyph_tag = 16'h0000;
                else
                    r.glyph_tag = 16'hFFFF;
                r.fill_ok = ($urandom_range(0, 99) < 85);
                offer(r, 1'b0, '0);
            end
        end

        // Wait out the owed results, then a stretch longer than one full
        // scan so that any stray result beat would still be seen.
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("glyph_cache_lru_tags regression: pass");
        else
            $display("glyph_cache_lru_tags regression: fail");
        $finish;
    end

endmodule
